[rtl/twei_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twei_pkg: shared types and constants
// Sizes, placement codes and front-to-back request format.
// ----------------------------------------------------------------------------
package twei_pkg;
    localparam int SLOTS = 16;
    localparam int TIERS = 4;
    localparam int ITEMS = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TIER_W = (TIERS > 1) ? $clog2(TIERS) : 1;
    localparam int HANDLE_W = $clog2(ITEMS);
    localparam int CNT_W = 11;
    localparam int TIME_W = 40;
    localparam int WIDE_W = 51;
    localparam logic [WIDE_W-1:0] BIG_CAP = WIDE_W'(1) << 50;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_TICK = 2'd1;
    localparam logic [1:0] CFG_SLOTS = 2'd2;

    typedef enum logic [1:0] {
        t_PL_CURRENT = 2'd0,
        t_PL_SLOT = 2'd1,
        t_PL_REJECT = 2'd2
    } t_place;

    typedef struct packed {
        t_place place;
        logic [TIER_W-1:0] tier;
        logic [SLOT_W-1:0] slot;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef enum logic [1:0] {
        t_FS_IDLE,
        t_FS_TIER,
        t_FS_DIV,
        t_FS_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        t_BS_IDLE,
        t_BS_READ,
        t_BS_WRITE,
        t_BS_OUT
    } t_bstate;

    function automatic logic [WIDE_W-1:0] sat_cap(input logic [WIDE_W+5:0] v);
        return (v > 57'(BIG_CAP)) ? BIG_CAP : v[WIDE_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction
endpackage
`default_nettype wire

[rtl/twei_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twei channel interfaces
// Valid/ready channels for insert requests and results.
// ----------------------------------------------------------------------------
interface twei_in_if;
    logic valid;
    logic ready;
    logic [39:0] event_time;
    logic [9:0] item_handle;
    logic past_to_current;
    modport source(output valid, event_time, item_handle, past_to_current, input ready);
    modport sink(input valid, event_time, item_handle, past_to_current, output ready);
endinterface

interface twei_out_if;
    logic valid;
    logic ready;
    logic [1:0] placement;
    logic [2:0] tier_number;
    logic [3:0] slot_number;
    logic [10:0] list_length;
    modport source(output valid, placement, tier_number, slot_number, list_length,
        input ready);
    modport sink(input valid, placement, tier_number, slot_number, list_length,
        output ready);
endinterface
`default_nettype wire

[rtl/twei_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twei_front: classify items
// Walks tiers one per cycle, then finds the slot by restoring division.
// ----------------------------------------------------------------------------
module twei_front (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [39:0] i_start_time,
    input  wire logic [23:0] i_tick_length,
    input  wire logic [4:0] i_slots_in_use,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic [39:0] i_event_time,
    input  wire logic [9:0] i_item_handle,
    input  wire logic i_past_to_current,
    output logic o_push,
    output twei_pkg::t_req o_req,
    input  wire logic i_full
);
    localparam int W = twei_pkg::WIDE_W;
    twei_pkg::t_fstate r_st, n_st;
    logic [W-1:0] r_t, n_t, r_s, n_s, r_w, n_w;
    logic [4:0] r_n, n_n;
    logic [twei_pkg::TIER_W-1:0] r_k, n_k;
    logic [twei_pkg::SLOT_W:0] r_q, n_q;
    logic [twei_pkg::SLOT_W:0] r_i, n_i;
    logic [twei_pkg::HANDLE_W-1:0] r_h, n_h;
    twei_pkg::t_req r_req, n_req;
    logic [W-1:0] span, diff, shw;
    logic [4:0] ncl;

    always_comb begin
        span = twei_pkg::sat_cap(57'(r_w) * 57'(r_n));
        diff = r_t - r_s;
        shw = r_w << r_i[twei_pkg::SLOT_W-1:0];
        ncl = (i_slots_in_use < 5'd2) ? 5'd2 :
            (i_slots_in_use > 5'(twei_pkg::SLOTS)) ? 5'(twei_pkg::SLOTS) : i_slots_in_use;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= twei_pkg::t_FS_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_t <= n_t; r_s <= n_s; r_w <= n_w; r_n <= n_n; r_k <= n_k;
        r_q <= n_q; r_i <= n_i; r_h <= n_h; r_req <= n_req;
    end

    always_comb begin
        n_st = r_st; n_t = r_t; n_s = r_s; n_w = r_w; n_n = r_n; n_k = r_k;
        n_q = r_q; n_i = r_i; n_h = r_h; n_req = r_req;
        o_ready = 1'b0;
        o_push = 1'b0;
        unique case (r_st)
            twei_pkg::t_FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_t = W'(i_event_time);
                    n_s = W'(i_start_time);
                    n_w = (i_tick_length == '0) ? W'(1) : W'(i_tick_length);
                    n_n = ncl;
                    n_k = '0;
                    n_h = i_item_handle;
                    if (i_past_to_current && i_event_time < i_start_time) begin
                        n_req = '{twei_pkg::t_PL_CURRENT, '0, '0, i_item_handle};
                        n_st = twei_pkg::t_FS_PUSH;
                    end else begin
                        n_st = twei_pkg::t_FS_TIER;
                    end
                end
            end
            twei_pkg::t_FS_TIER: begin
                if (r_t < r_s) begin
                    n_req = '{twei_pkg::t_PL_SLOT, r_k, '0, r_h};
                    n_st = twei_pkg::t_FS_PUSH;
                end else if (diff < span) begin
                    n_q = '0;
                    n_i = (twei_pkg::SLOT_W+1)'(twei_pkg::SLOT_W - 1);
                    n_t = diff;
                    n_st = twei_pkg::t_FS_DIV;
                end else if (32'(r_k) == twei_pkg::TIERS - 1) begin
                    n_req = '{twei_pkg::t_PL_REJECT, '0, '0, r_h};
                    n_st = twei_pkg::t_FS_PUSH;
                end else begin
                    n_s = twei_pkg::sat_cap(57'(r_s) + 57'(span));
                    n_w = span;
                    n_k = r_k + twei_pkg::TIER_W'(1);
                end
            end
            twei_pkg::t_FS_DIV: begin
                if ((r_w != '0) && (shw >> r_i[twei_pkg::SLOT_W-1:0]) == r_w
                    && r_t >= shw) begin
                    n_t = r_t - shw;
                    n_q = r_q | ((twei_pkg::SLOT_W+1)'(1) << r_i[twei_pkg::SLOT_W-1:0]);
                end
                if (r_i == '0) begin
                    n_req = '{twei_pkg::t_PL_SLOT, r_k, n_q[twei_pkg::SLOT_W-1:0], r_h};
                    n_st = twei_pkg::t_FS_PUSH;
                end else begin
                    n_i = r_i - (twei_pkg::SLOT_W+1)'(1);
                end
            end
            twei_pkg::t_FS_PUSH: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_st = twei_pkg::t_FS_IDLE;
                end
            end
            default: n_st = twei_pkg::t_FS_IDLE;
        endcase
    end

    assign o_req = r_req;
endmodule
`default_nettype wire

[rtl/twei_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twei_queue: two-entry request queue
// Decouples the classifier from the list updater.
// ----------------------------------------------------------------------------
module twei_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire twei_pkg::t_req i_req,
    output logic o_full,
    input  wire logic i_pop,
    output logic o_empty,
    output twei_pkg::t_req o_req
);
    twei_pkg::t_req r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_req;
    end

    assign o_full = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_req = r_mem[r_rp];

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
endmodule
`default_nettype wire

[rtl/twei_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twei_back: list updater
// Read-modify-write of slot count/head/tail and link memory, then result.
// ----------------------------------------------------------------------------
module twei_back (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire twei_pkg::t_req i_req,
    output logic o_pop,
    output logic o_valid,
    input  wire logic i_ready,
    output logic [1:0] o_placement,
    output logic [2:0] o_tier_number,
    output logic [3:0] o_slot_number,
    output logic [10:0] o_list_length
);
    localparam int AW = twei_pkg::TIER_W + twei_pkg::SLOT_W;
    localparam int NS = twei_pkg::TIERS * twei_pkg::SLOTS;
    localparam int HW = twei_pkg::HANDLE_W;
    localparam int CW = twei_pkg::CNT_W;

    twei_pkg::t_bstate r_st, n_st;
    logic [CW-1:0] r_cnt_mem [NS];
    logic [HW-1:0] r_head_mem [NS];
    logic [HW-1:0] r_tail_mem [NS];
    logic [HW:0] r_link_mem [twei_pkg::ITEMS];
    logic [NS-1:0] r_vld;
    logic [CW-1:0] r_tot [twei_pkg::TIERS];
    logic [CW-1:0] r_ccnt;
    logic [HW-1:0] r_chead, r_ctail;
    twei_pkg::t_req r_req, n_req;
    logic [CW-1:0] r_rcnt, r_len, n_len;
    logic [HW-1:0] r_rhead, r_rtail;
    logic [1:0] r_pl, n_pl;
    logic [2:0] r_tn, n_tn;
    logic [3:0] r_sn, n_sn;
    logic [AW-1:0] addr;
    logic [CW-1:0] cnt_eff, cnt_new;
    logic do_rd, do_wr;
    logic [HW:0] link_val;
    logic link_wr;

    assign addr = {r_req.tier, r_req.slot};
    assign cnt_eff = r_vld[addr] ? r_rcnt : '0;
    assign cnt_new = twei_pkg::sat_inc(r_req.place == twei_pkg::t_PL_CURRENT ? r_ccnt : cnt_eff);
    assign link_wr = do_wr && r_req.place != twei_pkg::t_PL_REJECT;
    assign link_val = (r_req.place == twei_pkg::t_PL_SLOT && cnt_eff != '0
        && r_req.tier != '0) ? {1'b0, r_rhead} : {1'b1, {HW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= twei_pkg::t_BS_IDLE;
            r_vld <= '0;
            r_ccnt <= '0;
            for (int k = 0; k < twei_pkg::TIERS; k++) r_tot[k] <= '0;
        end else begin
            r_st <= n_st;
            if (do_wr) begin
                if (r_req.place == twei_pkg::t_PL_CURRENT) begin
                    r_ccnt <= cnt_new;
                end else if (r_req.place == twei_pkg::t_PL_SLOT) begin
                    r_vld[addr] <= 1'b1;
                    for (int k = 0; k < twei_pkg::TIERS; k++)
                        if (k <= int'(r_req.tier)) r_tot[k] <= twei_pkg::sat_inc(r_tot[k]);
                end
            end
        end
        if (do_rd) begin
            r_rcnt <= r_cnt_mem[addr];
            r_rhead <= r_head_mem[addr];
            r_rtail <= r_tail_mem[addr];
        end
        if (do_wr) begin
            if (r_req.place == twei_pkg::t_PL_CURRENT) begin
                if (r_ccnt == '0) r_chead <= r_req.handle;
                else if (r_ctail != r_req.handle)
                    r_link_mem[r_ctail] <= {1'b0, r_req.handle};
                r_ctail <= r_req.handle;
            end else if (r_req.place == twei_pkg::t_PL_SLOT) begin
                r_cnt_mem[addr] <= cnt_new;
                if (cnt_eff == '0) begin
                    r_head_mem[addr] <= r_req.handle;
                    r_tail_mem[addr] <= r_req.handle;
                end else if (r_req.tier != '0) begin
                    r_head_mem[addr] <= r_req.handle;
                end else begin
                    if (r_rtail != r_req.handle)
                        r_link_mem[r_rtail] <= {1'b0, r_req.handle};
                    r_tail_mem[addr] <= r_req.handle;
                end
            end
        end
        if (link_wr) r_link_mem[r_req.handle] <= link_val;
        r_req <= n_req;
        r_len <= n_len; r_pl <= n_pl; r_tn <= n_tn; r_sn <= n_sn;
    end

    always_comb begin
        n_st = r_st; n_req = r_req; n_len = r_len; n_pl = r_pl; n_tn = r_tn; n_sn = r_sn;
        o_pop = 1'b0; do_rd = 1'b0; do_wr = 1'b0; o_valid = 1'b0;
        unique case (r_st)
            twei_pkg::t_BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_req = i_req;
                    n_st = twei_pkg::t_BS_READ;
                end
            end
            twei_pkg::t_BS_READ: begin
                do_rd = 1'b1;
                n_st = twei_pkg::t_BS_WRITE;
            end
            twei_pkg::t_BS_WRITE: begin
                do_wr = 1'b1;
                n_pl = r_req.place;
                n_tn = (r_req.place == twei_pkg::t_PL_SLOT) ? 3'(r_req.tier) : '0;
                n_sn = (r_req.place == twei_pkg::t_PL_SLOT) ? 4'(r_req.slot) : '0;
                n_len = (r_req.place == twei_pkg::t_PL_REJECT) ? '0 : cnt_new;
                n_st = twei_pkg::t_BS_OUT;
            end
            twei_pkg::t_BS_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_st = twei_pkg::t_BS_IDLE;
            end
            default: n_st = twei_pkg::t_BS_IDLE;
        endcase
    end

    assign o_placement = r_pl;
    assign o_tier_number = r_tn;
    assign o_slot_number = r_sn;
    assign o_list_length = r_len;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_st == twei_pkg::t_BS_READ) else $error("pop outside idle");
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_pl != 2'(twei_pkg::t_PL_REJECT) |-> r_len != '0)
        else $error("stored list empty");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_pl == 2'(twei_pkg::t_PL_REJECT) |-> r_len == '0 && r_tn == '0)
        else $error("reject fields");
endmodule
`default_nettype wire

[rtl/timing_wheel_event_insert.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timing_wheel_event_insert: timing wheel insert block
// Places timed events into a current list or a slot list of a tiered wheel.
// ----------------------------------------------------------------------------
// Input channel (in) takes event_time, item_handle, past_to_current; output
// channel (out) returns placement, tier, slot and new list length; one result
// per item, in order. Configuration must be written through i_cfg_* only
// while idle; the block itself does not enforce this. The front takes an
// item, walks up to TIERS tiers one per cycle, then runs a SLOT_W step
// restoring division for the slot index; it then pushes a request into a
// two-entry queue. The back reads the slot memories, writes them in the next
// cycle and holds the result until taken. The front takes a new item only
// after pushing the request for the last, and the back handles one request
// at a time. At reset the slot valid bits and the current and tier counters
// clear; no clearing pass is needed. A stalled receiver holds the back; the
// queue then fills and the front deasserts ready.
// ----------------------------------------------------------------------------
module timing_wheel_event_insert (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [39:0] i_cfg_data,
    twei_in_if.sink in,
    twei_out_if.source out
);
    logic [39:0] r_start;
    logic [23:0] r_tick;
    logic [4:0] r_slots;
    logic push, pop, full, empty;
    twei_pkg::t_req qin, qout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_tick <= 24'd256; r_slots <= 5'd16;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                twei_pkg::CFG_START: r_start <= i_cfg_data;
                twei_pkg::CFG_TICK: r_tick <= i_cfg_data[23:0];
                twei_pkg::CFG_SLOTS: r_slots <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    twei_front u_front (
        .i_clk, .i_rst_n,
        .i_start_time(r_start), .i_tick_length(r_tick), .i_slots_in_use(r_slots),
        .i_valid(in.valid), .o_ready(in.ready), .i_event_time(in.event_time),
        .i_item_handle(in.item_handle), .i_past_to_current(in.past_to_current),
        .o_push(push), .o_req(qin), .i_full(full)
    );

    twei_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_req(qin), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_req(qout)
    );

    twei_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_req(qout), .o_pop(pop),
        .o_valid(out.valid), .i_ready(out.ready), .o_placement(out.placement),
        .o_tier_number(out.tier_number), .o_slot_number(out.slot_number),
        .o_list_length(out.list_length)
    );
endmodule
`default_nettype wire
